// ===== hdl/round_robin_delay_task_scheduler_defines.svh =====
// ============================================================================
// Round-robin delay task scheduler - assertion macros
// Shared assertion helpers, clocked on aclk and disabled while aresetn is low.
// ============================================================================
`ifndef ROUND_ROBIN_DELAY_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_DELAY_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication check
`define RRDS_CHECK(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication check
`define RRDS_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scheduler sequence check failed");

`endif

// ===== hdl/rrds_pkg.sv =====
// ============================================================================
// rrds_pkg
// Types and constants for the round-robin delay task scheduler.
// ============================================================================
package rrds_pkg;

    // Default number of tasks
    localparam int TASK_COUNT_DEF = 8;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int DELAY_W    = 16;
    localparam int TASK_IDX_W = 3;
    localparam int TICK_W     = 13;

    // Stream widths (fields packed from bit 0, padded to bytes)
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    // ms -> ticks: x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam int          PROD_W      = 32;
    localparam int          DIV10_SHIFT = 19;
    localparam logic [15:0] DIV10_MUL   = 16'd52429;

    // Request kinds
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_DELAY = 2'd1,
        CMD_LOAD  = 2'd2
    } cmd_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_TICK,
        ST_SEARCH,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/round_robin_delay_task_scheduler.sv =====
// ============================================================================
// round_robin_delay_task_scheduler
// Cooperative round-robin scheduler with a 10 ms delay timer per task.
// ============================================================================
// One request at a time goes through a small sequencer that shares a single
// read port, decrementer and zero compare across the task timers, visiting one
// task per cycle. A tick request sweeps every task timer, then re-runs the
// ready search when the block is idle. A delay request, dropped while idle,
// writes the running task's timer and then searches from the next task;
// load and unused requests go straight to the result. The input is ready
// only while the sequencer is idle; a finished result waits in the output
// register and does not block the next request.
// tuser carries the request kind (0 tick, 1 delay and yield, 2 load task).
// ============================================================================
`include "round_robin_delay_task_scheduler_defines.svh"

module round_robin_delay_task_scheduler #(
    parameter int TASK_COUNT = rrds_pkg::TASK_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rrds_pkg::S_TDATA_W-1:0] s_tdata,  // [15:0] delay_ms, [18:16] task_index
    input  logic [rrds_pkg::CMD_W-1:0]     s_tuser,  // [1:0] command
    // Result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rrds_pkg::M_TDATA_W-1:0] m_tdata   // [2:0] running_task, [3] idle
);

    localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);

    // State and datapath registers
    rrds_pkg::state_t                     state_reg, state_next;
    logic [rrds_pkg::TICK_W-1:0]          ticks_reg [TASK_COUNT];
    logic [rrds_pkg::TICK_W-1:0]          ticks_next[TASK_COUNT];
    logic [IDX_W-1:0]                     current_reg, current_next;
    logic                                 waiting_reg, waiting_next;
    logic [IDX_W-1:0]                     idx_reg, idx_next;
    logic [IDX_W-1:0]                     cnt_reg, cnt_next;
    logic [rrds_pkg::PROD_W-1:0]          prod_reg, prod_next;
    logic                                 m_valid_reg, m_valid_next;
    logic [rrds_pkg::TASK_IDX_W-1:0]      run_reg, run_next;
    logic                                 idle_reg, idle_next;

    logic                                 s_accept;
    logic [rrds_pkg::TICK_W-1:0]          idx_ticks;
    logic [IDX_W-1:0]                     idx_inc;
    logic [IDX_W-1:0]                     current_inc;
    logic [rrds_pkg::TASK_IDX_W-1:0]      req_task;
    logic [IDX_W-1:0]                     load_idx;

    assign s_tready = (state_reg == rrds_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(rrds_pkg::M_TDATA_W - rrds_pkg::TASK_IDX_W - 1){1'b0}},
                       idle_reg, run_reg};

    // Shared read port and index wrap logic
    assign idx_ticks   = ticks_reg[idx_reg];
    assign idx_inc     = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign current_inc = (current_reg == LAST_IDX) ? '0 : current_reg + 1'b1;
    assign req_task    = s_tdata[rrds_pkg::DELAY_W +: rrds_pkg::TASK_IDX_W];
    assign load_idx    = IDX_W'(req_task);

    // State register and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rrds_pkg::ST_IDLE;
            current_reg <= '0;
            waiting_reg <= 1'b0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < TASK_COUNT; i++) begin
                ticks_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            current_reg <= current_next;
            waiting_reg <= waiting_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < TASK_COUNT; i++) begin
                ticks_reg[i] <= ticks_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        run_reg  <= run_next;
        idle_reg <= idle_next;
    end

    // Sequencer: next state and datapath updates
    always_comb begin
        state_next   = state_reg;
        ticks_next   = ticks_reg;
        current_next = current_reg;
        waiting_next = waiting_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        prod_next    = prod_reg;
        run_next     = run_reg;
        idle_next    = idle_reg;
        m_valid_next = m_valid_reg;

        // Result taken downstream
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            rrds_pkg::ST_IDLE: begin
                if (s_accept) begin
                    // ms to ticks by reciprocal multiply
                    prod_next = rrds_pkg::PROD_W'(s_tdata[rrds_pkg::DELAY_W-1:0])
                              * rrds_pkg::PROD_W'(rrds_pkg::DIV10_MUL);
                    unique case (s_tuser)
                        rrds_pkg::CMD_TICK: begin
                            idx_next   = '0;
                            state_next = rrds_pkg::ST_TICK;
                        end
                        rrds_pkg::CMD_DELAY: begin
                            // no running task can yield while idle
                            state_next = waiting_reg ? rrds_pkg::ST_DONE
                                                     : rrds_pkg::ST_WRITE;
                        end
                        rrds_pkg::CMD_LOAD: begin
                            if (int'(req_task) < TASK_COUNT) begin
                                ticks_next[load_idx] = '0;
                            end
                            state_next = rrds_pkg::ST_DONE;
                        end
                        default: begin
                            state_next = rrds_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            rrds_pkg::ST_WRITE: begin
                // load current task's timer, then search from the next task
                ticks_next[current_reg] =
                    prod_reg[rrds_pkg::DIV10_SHIFT +: rrds_pkg::TICK_W];
                idx_next   = current_inc;
                cnt_next   = '0;
                state_next = rrds_pkg::ST_SEARCH;
            end

            rrds_pkg::ST_TICK: begin
                // decrement one nonzero timer per cycle
                if (idx_ticks != '0) begin
                    ticks_next[idx_reg] = idx_ticks - 1'b1;
                end
                if (idx_reg == LAST_IDX) begin
                    if (waiting_reg) begin
                        idx_next   = current_inc;
                        cnt_next   = '0;
                        state_next = rrds_pkg::ST_SEARCH;
                    end else begin
                        state_next = rrds_pkg::ST_DONE;
                    end
                end else begin
                    idx_next = idx_inc;
                end
            end

            rrds_pkg::ST_SEARCH: begin
                // one candidate per cycle, current task tried last
                if (idx_ticks == '0) begin
                    current_next = idx_reg;
                    waiting_next = 1'b0;
                    state_next   = rrds_pkg::ST_DONE;
                end else if (cnt_reg == LAST_IDX) begin
                    waiting_next = 1'b1;
                    state_next   = rrds_pkg::ST_DONE;
                end else begin
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            rrds_pkg::ST_DONE: begin
                // hand the result to the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    run_next     = rrds_pkg::TASK_IDX_W'(current_reg);
                    idle_next    = waiting_reg;
                    state_next   = rrds_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = rrds_pkg::ST_IDLE;
            end
        endcase
    end

    // Checks
    `RRDS_CHECK(a_running_task_ready,
                (state_reg == rrds_pkg::ST_IDLE) && !waiting_reg,
                ticks_reg[current_reg] == '0)
    `RRDS_CHECK(a_idx_in_range, 1'b1,
                (int'(idx_reg) < TASK_COUNT) && (int'(cnt_reg) < TASK_COUNT))
    `RRDS_CHECK_NEXT(a_tick_starts_sweep,
                     s_accept && (s_tuser == rrds_pkg::CMD_TICK),
                     (state_reg == rrds_pkg::ST_TICK) && (idx_reg == '0))

endmodule

// ===== verif/rrds_checker.sv =====
// ============================================================================
// rrds_checker
// Watches both stream channels of the round-robin delay task scheduler, keeps
// its own copy of the task timers and running task, predicts the result of
// each accepted request and compares it field by field with the block's output.
// ============================================================================
`timescale 1ns / 100ps

module rrds_checker #(
    parameter int TASK_COUNT = rrds_pkg::TASK_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [rrds_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] delay_ms, [18:16] task_index
    input  logic [rrds_pkg::CMD_W-1:0]     s_tuser,   // [1:0] command
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [rrds_pkg::M_TDATA_W-1:0] m_tdata,   // [2:0] running_task, [3] idle
    output int                             fail_count,
    output int                             pending,
    output int                             checked_count,
    output int                             idle_count
);

    localparam int MS_PER_TICK = 10;

    typedef struct packed {
        logic [rrds_pkg::TASK_IDX_W-1:0] running_task;
        logic                            idle;
    } pick_t;

    // Local copy of the scheduler state
    logic [rrds_pkg::TICK_W-1:0]     timer_copy [TASK_COUNT];
    logic [rrds_pkg::TASK_IDX_W-1:0] cur_task;
    logic                            waiting;

    pick_t predicted_picks [$];

    // Round-robin search from the task after cur_task, cur_task last
    function automatic void find_ready_task();
        logic [rrds_pkg::TASK_IDX_W-1:0] cand;
        cand = cur_task;
        for (int n = 0; n < TASK_COUNT; n++) begin
            cand = (cand == rrds_pkg::TASK_IDX_W'(TASK_COUNT - 1)) ? '0 : cand + 1'b1;
            if (timer_copy[cand] == '0) begin
                cur_task = cand;
                waiting  = 1'b0;
                return;
            end
        end
        waiting = 1'b1;
    endfunction

    // Apply one request to the local state and return the resulting pick
    function automatic pick_t advance_scheduler(
        logic [rrds_pkg::CMD_W-1:0]      cmd,
        logic [rrds_pkg::DELAY_W-1:0]    ms,
        logic [rrds_pkg::TASK_IDX_W-1:0] idx);
        pick_t r;
        case (cmd)
            rrds_pkg::CMD_TICK: begin
                // decrement first, then retry the search if idle
                for (int i = 0; i < TASK_COUNT; i++)
                    if (timer_copy[i] != '0)
                        timer_copy[i] = timer_copy[i] - 1'b1;
                if (waiting)
                    find_ready_task();
            end
            rrds_pkg::CMD_DELAY: begin
                // ignored while idle: nobody is running to delay
                if (!waiting) begin
                    timer_copy[cur_task] = rrds_pkg::TICK_W'(ms / MS_PER_TICK);
                    find_ready_task();
                end
            end
            rrds_pkg::CMD_LOAD: begin
                if (idx < TASK_COUNT)
                    timer_copy[idx] = '0;
            end
            default: ;
        endcase
        r.running_task = cur_task;
        r.idle         = waiting;
        return r;
    endfunction

    // Track requests and results
    always @(posedge aclk) begin
        pick_t got;
        pick_t want;
        if (!aresetn) begin
            for (int i = 0; i < TASK_COUNT; i++)
                timer_copy[i] = '0;
            cur_task = '0;
            waiting  = 1'b0;
            predicted_picks.delete();
        end else begin
            // result first: it always belongs to an older request
            if (m_tvalid && m_tready) begin
                got.running_task = m_tdata[rrds_pkg::TASK_IDX_W-1:0];
                got.idle         = m_tdata[rrds_pkg::TASK_IDX_W];
                if (predicted_picks.size() == 0) begin
                    $error("result with no request outstanding: running_task %0d idle %0d",
                           got.running_task, got.idle);
                    fail_count++;
                end else begin
                    want = predicted_picks.pop_front();
                    checked_count++;
                    if (want.idle)
                        idle_count++;
                    if (got.running_task !== want.running_task) begin
                        $error("running_task mismatch: expected %0d, got %0d",
                               want.running_task, got.running_task);
                        fail_count++;
                    end
                    if (got.idle !== want.idle) begin
                        $error("idle mismatch: expected %0d, got %0d", want.idle, got.idle);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predicted_picks.push_back(
                    advance_scheduler(s_tuser, s_tdata[rrds_pkg::DELAY_W-1:0],
                                      s_tdata[rrds_pkg::DELAY_W +: rrds_pkg::TASK_IDX_W]));
        end
        pending <= predicted_picks.size();
    end

endmodule

// ===== verif/tb.sv =====
// ============================================================================
// tb
// Testbench top for the round-robin delay task scheduler: drives a directed
// walk through the idle and yield corner cases, then random tick, delay, load and
// unused requests with random gaps and back-pressure, and reports the verdict.
// ============================================================================
`timescale 1ns / 100ps

module tb;

    localparam logic [rrds_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;   // unused request kind
    localparam int RANDOM_REQS  = 410;
    localparam int STEADY_FROM  = 355;   // last stretch runs with no gaps or back-pressure
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT  = 2000;

    logic                           aclk;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [rrds_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [rrds_pkg::CMD_W-1:0]     s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rrds_pkg::M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int checked_count;
    int idle_count;

    int          sent_count = 0;
    int          useful     = 0;
    bit          steady     = 1'b0;
    int unsigned stall_left = 0;
    int          quiet      = 0;

    round_robin_delay_task_scheduler uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rrds_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .idle_count    (idle_count)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!steady && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 10);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("Watchdog: no request or result moved for %0d cycles", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Present one request and hold it until accepted, then maybe pause
    task automatic send_request(input logic [rrds_pkg::CMD_W-1:0]      cmd,
                                input logic [rrds_pkg::DELAY_W-1:0]    ms,
                                input logic [rrds_pkg::TASK_IDX_W-1:0] idx,
                                input bit                              allow_gap);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(rrds_pkg::S_TDATA_W - rrds_pkg::DELAY_W - rrds_pkg::TASK_IDX_W){1'b0}},
                     idx, ms};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
        if (allow_gap && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Stimulus and verdict
    initial begin
        logic [rrds_pkg::CMD_W-1:0]      cmd;
        logic [rrds_pkg::DELAY_W-1:0]    ms;
        logic [rrds_pkg::TASK_IDX_W-1:0] idx;
        int                              pick;
        int                              directed;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: fill every task timer until idle, then recover
        send_request(rrds_pkg::CMD_TICK,  16'd0,    3'd0, 1'b1);  // tick with nothing to count
        send_request(CMD_SPARE,           16'hFFFF, 3'd7, 1'b1);  // unused kind, all bits set
        send_request(rrds_pkg::CMD_DELAY, 16'hFFFF, 3'd0, 1'b0);  // longest delay on task 0
        send_request(rrds_pkg::CMD_DELAY, 16'd30,   3'd5, 1'b1);
        send_request(rrds_pkg::CMD_DELAY, 16'd20,   3'd2, 1'b0);
        send_request(rrds_pkg::CMD_DELAY, 16'd10,   3'd1, 1'b1);
        send_request(rrds_pkg::CMD_DELAY, 16'd40,   3'd6, 1'b0);
        send_request(rrds_pkg::CMD_DELAY, 16'd50,   3'd3, 1'b1);
        send_request(rrds_pkg::CMD_DELAY, 16'd60,   3'd4, 1'b0);
        send_request(rrds_pkg::CMD_DELAY, 16'd9,    3'd7, 1'b1);  // under one tick: task 7 reruns
        send_request(rrds_pkg::CMD_DELAY, 16'd19,   3'd0, 1'b0);  // all busy: goes idle
        send_request(rrds_pkg::CMD_DELAY, 16'd100,  3'd1, 1'b1);  // yield while idle is dropped
        send_request(rrds_pkg::CMD_LOAD,  16'd0,    3'd5, 1'b0);  // load while idle: no search
        send_request(rrds_pkg::CMD_TICK,  16'h5555, 3'd2, 1'b1);  // decrement, then search
        send_request(rrds_pkg::CMD_TICK,  16'hAAAA, 3'd5, 1'b0);
        send_request(rrds_pkg::CMD_LOAD,  16'hFFFF, 3'd0, 1'b1);  // clear the long timer
        send_request(rrds_pkg::CMD_DELAY, 16'd0,    3'd3, 1'b0);  // zero delay
        send_request(rrds_pkg::CMD_LOAD,  16'd0,    3'd7, 1'b1);
        send_request(CMD_SPARE,           16'd0,    3'd0, 1'b0);
        send_request(rrds_pkg::CMD_TICK,  16'd0,    3'd0, 1'b1);
        send_request(rrds_pkg::CMD_TICK,  16'd0,    3'd0, 1'b1);
        directed = sent_count;

        // Random: mostly short delays so tasks cycle through busy and ready
        while (useful < RANDOM_REQS) begin
            pick = $urandom_range(0, 99);
            ms   = rrds_pkg::DELAY_W'($urandom_range(0, 65535));
            idx  = rrds_pkg::TASK_IDX_W'($urandom_range(0, 7));
            if (pick < 40) begin
                cmd = rrds_pkg::CMD_TICK;
            end else if (pick < 75) begin
                cmd = rrds_pkg::CMD_DELAY;
                if ($urandom_range(0, 99) < 85)
                    ms = rrds_pkg::DELAY_W'($urandom_range(0, 99));
            end else if (pick < 95) begin
                cmd = rrds_pkg::CMD_LOAD;
            end else begin
                cmd = CMD_SPARE;
            end
            if (cmd != CMD_SPARE)
                useful++;
            steady = (useful >= STEADY_FROM);
            send_request(cmd, ms, idx, !steady && ((useful / 50) % 4 != 1));
            // hold off once until the block has answered everything
            if (useful == RANDOM_REQS / 2 && cmd != CMD_SPARE)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests (%0d directed, rest random tick/delay/load/unused).",
                 sent_count, directed);
        $display("Checked %0d results, %0d of them with the scheduler idle.",
                 checked_count, idle_count);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
